// ----- sv/ssup_pkg.sv -----
package ssup_pkg;

  // default depth of the event ring
  localparam int EVENT_DEPTH_DEFAULT = 16;

  // supervisor state encoding as seen on the output
  localparam logic [1:0] ST_RUNNING   = 2'd0;
  localparam logic [1:0] ST_DEGRADED  = 2'd1;
  localparam logic [1:0] ST_SAFE_STOP = 2'd2;
  localparam logic [1:0] ST_LATCHED   = 2'd3;

  // item kinds carried in tuser
  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_POP    = 2'd2;
  localparam logic [1:0] MODE_PEEK   = 2'd3;

  // number of fault flags
  localparam int FLAG_W = 6;

  // one logged transition
  typedef struct packed {
    logic [15:0]       extra;
    logic [1:0]        to_state;
    logic [1:0]        from_state;
    logic [FLAG_W-1:0] sources;
    logic [31:0]       time_ms;
  } ssup_entry_t;

  // per-item status from the control unit
  typedef struct packed {
    logic [1:0] state_now;
    logic       allow;
    logic       ev_valid;
  } ssup_status_t;

  // priority decode of the fault flags
  function automatic logic [1:0] target_of(input logic [FLAG_W-1:0] flags);
    logic [1:0] t;
    if (flags[5]) begin
      t = ST_LATCHED;
    end else if (flags[1] || flags[4]) begin
      t = ST_SAFE_STOP;
    end else if (flags[0] || flags[2] || flags[3]) begin
      t = ST_DEGRADED;
    end else begin
      t = ST_RUNNING;
    end
    return t;
  endfunction

  // actuation only in running or degraded
  function automatic logic permit_of(input logic [1:0] st);
    return (st == ST_RUNNING) || (st == ST_DEGRADED);
  endfunction

endpackage

// ----- sv/ssup_log_mem.sv -----
module ssup_log_mem #(
  parameter int EVENT_DEPTH = 16,
  parameter int PW = $clog2(EVENT_DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [PW-1:0]        wr_addr,
  input  ssup_pkg::ssup_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [PW-1:0]        rd_addr,
  output ssup_pkg::ssup_entry_t rd_data
);
  import ssup_pkg::*;

  ssup_entry_t mem [EVENT_DEPTH];

  // event ring storage, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/ssup_ctrl.sv -----
module ssup_ctrl #(
  parameter int EVENT_DEPTH = 16,
  parameter int PW = $clog2(EVENT_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [1:0]                    mode,
  input  logic [ssup_pkg::FLAG_W-1:0]   flags,
  input  logic [31:0]                   time_ms,
  input  logic [15:0]                   aux_code,
  output logic                          wr_en,
  output logic [PW-1:0]                 wr_addr,
  output ssup_pkg::ssup_entry_t         wr_data,
  output logic                          rd_en,
  output logic [PW-1:0]                 rd_addr,
  output ssup_pkg::ssup_status_t        status
);
  import ssup_pkg::*;

  localparam logic [PW-1:0] LAST_IDX = PW'(EVENT_DEPTH - 1);

  logic [1:0]        cur_state, cur_state_next;
  logic              allow_flag, allow_flag_next;
  logic [FLAG_W-1:0] last_flags, last_flags_next;
  logic [PW-1:0]     wr_ptr, wr_ptr_next;
  logic [PW-1:0]     rd_ptr, rd_ptr_next;
  logic [PW-1:0]     wr_inc, rd_inc, wr_dec;
  logic [1:0]        tgt;
  logic              ring_empty;
  logic              ev_valid;

  // ring pointer arithmetic with wrap at the depth
  assign wr_inc = (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
  assign rd_inc = (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
  assign wr_dec = (wr_ptr == '0) ? LAST_IDX : wr_ptr - 1'b1;
  assign ring_empty = (rd_ptr == wr_ptr);
  assign tgt = target_of(flags);

  // entry logged on a change of state
  assign wr_addr = wr_ptr;
  assign wr_data = '{extra: aux_code, to_state: tgt, from_state: cur_state,
                     sources: flags, time_ms: time_ms};

  // per-item state update and ring access
  always_comb begin
    cur_state_next  = cur_state;
    allow_flag_next = allow_flag;
    last_flags_next = last_flags;
    wr_ptr_next     = wr_ptr;
    rd_ptr_next     = rd_ptr;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = rd_ptr;
    ev_valid        = 1'b0;
    if (accept) begin
      unique case (mode)
        MODE_UPDATE: begin
          last_flags_next = flags;
          if (cur_state == ST_LATCHED) begin
            allow_flag_next = 1'b0;
          end else begin
            if (tgt != cur_state) begin
              cur_state_next = tgt;
              wr_en          = 1'b1;
              wr_ptr_next    = wr_inc;
              if (wr_inc == rd_ptr) begin
                rd_ptr_next = rd_inc;
              end
            end
            allow_flag_next = permit_of(tgt);
          end
        end
        MODE_CLEAR: begin
          if (cur_state == ST_LATCHED) begin
            cur_state_next  = target_of(last_flags);
            allow_flag_next = permit_of(target_of(last_flags));
          end
        end
        MODE_POP: begin
          if (!ring_empty) begin
            ev_valid    = 1'b1;
            rd_en       = 1'b1;
            rd_ptr_next = rd_inc;
          end
        end
        MODE_PEEK: begin
          if (!ring_empty) begin
            ev_valid = 1'b1;
            rd_en    = 1'b1;
            rd_addr  = wr_dec;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status = '{state_now: cur_state_next, allow: allow_flag_next, ev_valid: ev_valid};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state  <= ST_RUNNING;
      allow_flag <= 1'b1;
      last_flags <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
    end else begin
      cur_state  <= cur_state_next;
      allow_flag <= allow_flag_next;
      last_flags <= last_flags_next;
      wr_ptr     <= wr_ptr_next;
      rd_ptr     <= rd_ptr_next;
    end
  end

`ifndef SYNTHESIS
  // permit always follows the state
  a_allow_matches_state: assert property (@(posedge clk) disable iff (rst)
    allow_flag == permit_of(cur_state))
    else $error("actuation permit out of step with state");

  // a logged event leaves the ring non-empty
  a_log_nonempty: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (rd_ptr != wr_ptr))
    else $error("ring empty right after logging");

  // a pop of a non-empty ring moves the read pointer
  a_pop_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_POP && !ring_empty) |=> (rd_ptr != $past(rd_ptr)))
    else $error("pop did not advance read pointer");
`endif

endmodule

// ----- sv/safety_state_supervisor_top.sv -----
// flow: an accepted word waits in stage s1 for the registered ring read and is
//   then loaded into the output register whenever that register is free to take it
// throughput: one word per cycle unless the output stalls; a word needs at most one
//   ring write and one registered ring read, and each stage refills in the cycle it drains
// reset: synchronous active-high rst puts the state at running with actuation
//   allowed, clears the stored flags and empties the event ring
module safety_state_supervisor_top #(
  parameter int EVENT_DEPTH = ssup_pkg::EVENT_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // battery_low_limit, battery_cutoff, link_lost, imu_failure,
  // period_abnormal, severe_fault, time_ms[31:0], aux_code[15:0], zero pad
  input  logic [55:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // state_now[1:0], allow_actuation, event_time[31:0], event_sources[5:0],
  // event_old_state[1:0], event_new_state[1:0], event_extra[15:0], zero pad
  output logic [63:0] m_axis_tdata,
  // event_valid
  output logic [0:0]  m_axis_tuser
);
  import ssup_pkg::*;

  localparam int PW = $clog2(EVENT_DEPTH);

  logic         accept;
  logic         s1_valid, s1_move;
  ssup_status_t s1_status, status;
  logic         wr_en, rd_en;
  logic [PW-1:0] wr_addr, rd_addr;
  ssup_entry_t  wr_data, rd_data, ev;

  // input side stays open while stage s1 is empty or can drain
  assign s1_move       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ssup_ctrl #(.EVENT_DEPTH(EVENT_DEPTH), .PW(PW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (s_axis_tuser),
    .flags      (s_axis_tdata[5:0]),
    .time_ms    (s_axis_tdata[37:6]),
    .aux_code   (s_axis_tdata[53:38]),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .status     (status)
  );

  ssup_log_mem #(.EVENT_DEPTH(EVENT_DEPTH), .PW(PW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // stage waiting for the ring read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status;
    end
  end

  // event fields read as zero when no event was returned
  assign ev = s1_status.ev_valid ? rd_data : '0;

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_axis_tdata <= {3'b000, ev.extra, ev.to_state, ev.from_state, ev.sources,
                       ev.time_ms, s1_status.allow, s1_status.state_now};
      m_axis_tuser <= s1_status.ev_valid;
    end
  end

endmodule
